@@ rtl/core/xtea_pkg.sv @@
// package for the xtea block cipher: item types, command struct, constants
// and the round mixing function; used by every module of the block
`timescale 1ns / 1ps

package xtea_pkg;

   localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;
   localparam int unsigned KEY_WORDS  = 4;
   localparam int unsigned CSR_IDX_W  = 8;

   // kind codes
   localparam logic KIND_ENCIPHER = 1'b0;
   localparam logic KIND_DECIPHER = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] word_a;
      logic [31:0] word_b;
   } xtea_req_type;

   typedef struct packed {
      logic [31:0] out_a;
      logic [31:0] out_b;
   } xtea_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic capture;
   } xtea_cmd_type;

   // ((v << 4) ^ (v >> 5)) + v
   function automatic logic [31:0] xtea_mix(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

@@ rtl/core/xtea_datapath.sv @@
// xtea datapath: key registers, block and sum registers, one full round per
// step, result register; depends on xtea_pkg
`timescale 1ns / 1ps

module xtea_datapath
   import xtea_pkg::*;
#(
   parameter int NUM_CYCLES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  xtea_cmd_type         cmd,
   input  xtea_req_type         req_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output xtea_rsp_type         rsp_data
);

   localparam logic [63:0] SUM_FULL = 64'(XTEA_DELTA) * 64'(NUM_CYCLES);
   localparam logic [31:0] SUM_DEC  = SUM_FULL[31:0];

   logic [31:0]  key_ff [KEY_WORDS];
   logic [31:0]  v0_ff, v0_in;
   logic [31:0]  v1_ff, v1_in;
   logic [31:0]  sum_ff, sum_in;
   logic         kind_ff;
   xtea_rsp_type out_ff;

   logic [31:0]  enc_sum, enc_v0, enc_v1;
   logic [31:0]  dec_sum, dec_v0, dec_v1;
   logic [31:0]  rnd_v0, rnd_v1, rnd_sum;

   // key words, written through the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_write && (csr_index < CSR_IDX_W'(KEY_WORDS))) begin
         key_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // encipher round: v0 half then v1 half
   always_comb begin
      enc_v0  = v0_ff + (xtea_mix(v1_ff) ^ (sum_ff + key_ff[sum_ff[1:0]]));
      enc_sum = sum_ff + XTEA_DELTA;
      enc_v1  = v1_ff + (xtea_mix(enc_v0) ^ (enc_sum + key_ff[enc_sum[12:11]]));
   end

   // decipher round: v1 half then v0 half
   always_comb begin
      dec_v1  = v1_ff - (xtea_mix(v0_ff) ^ (sum_ff + key_ff[sum_ff[12:11]]));
      dec_sum = sum_ff - XTEA_DELTA;
      dec_v0  = v0_ff - (xtea_mix(dec_v1) ^ (dec_sum + key_ff[dec_sum[1:0]]));
   end

   assign rnd_v0  = (kind_ff == KIND_DECIPHER) ? dec_v0  : enc_v0;
   assign rnd_v1  = (kind_ff == KIND_DECIPHER) ? dec_v1  : enc_v1;
   assign rnd_sum = (kind_ff == KIND_DECIPHER) ? dec_sum : enc_sum;

   // next block state: load wins over step
   always_comb begin
      v0_in  = v0_ff;
      v1_in  = v1_ff;
      sum_in = sum_ff;
      if (cmd.load) begin
         v0_in  = req_data.word_a;
         v1_in  = req_data.word_b;
         sum_in = (req_data.kind == KIND_DECIPHER) ? SUM_DEC : '0;
      end else if (cmd.step) begin
         v0_in  = rnd_v0;
         v1_in  = rnd_v1;
         sum_in = rnd_sum;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v0_ff  <= v0_in;
      v1_ff  <= v1_in;
      sum_ff <= sum_in;
      if (cmd.load) begin
         kind_ff <= req_data.kind;
      end
      if (cmd.capture) begin
         out_ff.out_a <= rnd_v0;
         out_ff.out_b <= rnd_v1;
      end
   end

   assign rsp_data = out_ff;

endmodule

@@ rtl/core/xtea_ctrl.sv @@
// xtea controller: idle/run state machine, round counter and result valid;
// depends on xtea_pkg
`timescale 1ns / 1ps

module xtea_ctrl
   import xtea_pkg::*;
#(
   parameter int NUM_CYCLES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output xtea_cmd_type cmd
);

   localparam int CNT_W = $clog2(NUM_CYCLES + 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             last;
   logic             accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last      = (count_ff == CNT_W'(1));
   // no item is taken while reset is held
   assign req_ready = !reset &&
                      ((state_ff == ST_IDLE) || ((state_ff == ST_RUN) && last && out_free));
   assign accept    = req_valid && req_ready;

   // commands; the final round stalls while the result register is full
   always_comb begin
      cmd.load    = accept;
      cmd.step    = (state_ff == ST_RUN) && (!last || out_free);
      cmd.capture = (state_ff == ST_RUN) && last && out_free;
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               count_in = CNT_W'(NUM_CYCLES);
            end
         end
         ST_RUN: begin
            if (cmd.capture) begin
               rsp_valid_in = 1'b1;
               if (accept) begin
                  count_in = CNT_W'(NUM_CYCLES);
               end else begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end
            end else if (cmd.step) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/xtea_block_cipher.sv @@
// xtea block cipher top level: controller plus datapath, csr key port
// depends on xtea_pkg, xtea_ctrl and xtea_datapath
//
// usage:
//   req channel (req_valid/req_ready/req_data) takes one item: a 64-bit block
//   as word_a/word_b and a kind bit (0 encipher, 1 decipher).
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns the transformed words.
//   csr channel writes key words 0..3 by csr_index; other indexes are dropped.
//   csr_ready is high outside reset; write the key only while no item is in flight.
// rounds and overlap:
//   one xtea cycle (two feistel half-rounds) per clock in the round unit,
//   unless the final round is held (see stalls). the next item is accepted
//   in the clock of the final round, so the block takes a new item before
//   it is through with the last one while the receiver keeps up.
// stalls: a finished result waits in the output register; if it is still
//   untaken when the next item reaches its final round, that round holds
//   and req_ready stays low until the output register frees up.
// reset: synchronous, clears the state machine, result valid and the key
//   (all zeros); req_ready and csr_ready stay low while reset is high.
`timescale 1ns / 1ps

module xtea_block_cipher
   import xtea_pkg::*;
#(
   parameter int NUM_CYCLES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  xtea_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output xtea_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   xtea_cmd_type cmd;

   assign csr_ready = !reset;

   // sequencer
   xtea_ctrl #(
      .NUM_CYCLES(NUM_CYCLES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd)
   );

   // round unit and registers
   xtea_datapath #(
      .NUM_CYCLES(NUM_CYCLES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // a finished item never overwrites a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // a captured result shows up on the rsp channel next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_valid)
      else $error("captured result not presented");

   // a new item only loads while no round is in progress, or with the final one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.step) |-> cmd.capture)
      else $error("item loaded over a running block");

   // accept implies a load command
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> cmd.load)
      else $error("accepted item not loaded");
`endif

endmodule

@@ tb/sv/tb_xtea_block_cipher.sv @@
// self-checking testbench for xtea_block_cipher: random valid/ready traffic,
// key writes between phases, in-bench xtea predictor; depends on xtea_pkg
`timescale 1ns / 1ps

module tb_xtea_block_cipher;
   import xtea_pkg::*;

   localparam int NUM_CYCLES       = 32;
   localparam int PHASE_COUNT      = 6;
   localparam int ITEMS_PER_PHASE  = 64;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 2000;

   // key register indexes, plus indexes the block drops
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3 = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP    = 8'hff;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   xtea_req_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   xtea_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data  = '0;

   logic [31:0]  key_model [KEY_WORDS] = '{default: '0};
   xtea_req_type pending_blocks [$];
   xtea_rsp_type expected_blocks [$];
   xtea_rsp_type exp_blk;
   bit           idle_on        = 1'b1;
   bit           long_hold_done = 1'b0;
   int           send_gap       = 0;
   int           stall_left     = 0;
   int           items_sent     = 0;
   int           error_count    = 0;
   int           quiet_cycles   = 0;

   xtea_block_cipher #(
      .NUM_CYCLES(NUM_CYCLES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // feistel mixing term of one half-round
   function automatic logic [31:0] feistel_mix(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   // full xtea run on one block under the current key copy
   function automatic xtea_rsp_type xtea_transform(input xtea_req_type blk);
      logic [31:0]  v0;
      logic [31:0]  v1;
      logic [31:0]  sum;
      xtea_rsp_type res;
      v0 = blk.word_a;
      v1 = blk.word_b;
      if (blk.kind == KIND_ENCIPHER) begin
         sum = '0;
         for (int n = 0; n < NUM_CYCLES; n++) begin
            v0 += feistel_mix(v1) ^ (sum + key_model[sum[1:0]]);
            sum += XTEA_DELTA;
            v1 += feistel_mix(v0) ^ (sum + key_model[sum[12:11]]);
         end
      end else begin
         // start sum wraps modulo 2^32
         sum = XTEA_DELTA * 32'(NUM_CYCLES);
         for (int n = 0; n < NUM_CYCLES; n++) begin
            v1 -= feistel_mix(v0) ^ (sum + key_model[sum[12:11]]);
            sum -= XTEA_DELTA;
            v0 -= feistel_mix(v1) ^ (sum + key_model[sum[1:0]]);
         end
      end
      res.out_a = v0;
      res.out_b = v1;
      return res;
   endfunction

   // random word biased toward the extremes
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_block(input logic kind, input logic [31:0] a, input logic [31:0] b);
      xtea_req_type blk;
      blk.kind   = kind;
      blk.word_a = a;
      blk.word_b = b;
      pending_blocks.push_back(blk);
   endtask

   // encipher a block, then decipher the resulting cipher text
   task automatic push_round_trip(input logic [31:0] a, input logic [31:0] b);
      xtea_req_type blk;
      xtea_rsp_type cipher;
      blk.kind   = KIND_ENCIPHER;
      blk.word_a = a;
      blk.word_b = b;
      cipher     = xtea_transform(blk);
      pending_blocks.push_back(blk);
      push_block(KIND_DECIPHER, cipher.out_a, cipher.out_b);
   endtask

   task automatic write_key_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_key(input logic [31:0] w0, input logic [31:0] w1,
                           input logic [31:0] w2, input logic [31:0] w3);
      write_key_reg(CSR_KEY_WORD0, w0);
      write_key_reg(CSR_KEY_WORD1, w1);
      write_key_reg(CSR_KEY_WORD2, w2);
      write_key_reg(CSR_KEY_WORD3, w3);
   endtask

   // wait until every block is sent and answered, then let the core settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_blocks.size() != 0 || req_valid || expected_blocks.size() != 0);
      repeat (NUM_CYCLES + 4) @(posedge clock);
   endtask

   // key copy follows accepted csr writes
   always @(posedge clock) begin
      if (reset) begin
         key_model <= '{default: '0};
      end else if (csr_valid && csr_ready && csr_index < KEY_WORDS) begin
         key_model[csr_index[1:0]] <= csr_data;
      end
   end

   // request driver with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_blocks.push_back(xtea_transform(req_data));
            items_sent <= items_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
               send_gap  <= $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (pending_blocks.size() != 0) begin
               req_data  <= pending_blocks.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $error("unexpected result out_a=%h out_b=%h", rsp_data.out_a, rsp_data.out_b);
               error_count++;
            end else begin
               exp_blk = expected_blocks.pop_front();
               if (rsp_data.out_a !== exp_blk.out_a) begin
                  $error("out_a expected %h actual %h", exp_blk.out_a, rsp_data.out_a);
                  error_count++;
               end
               if (rsp_data.out_b !== exp_blk.out_b) begin
                  $error("out_b expected %h actual %h", exp_blk.out_b, rsp_data.out_b);
                  error_count++;
               end
            end
         end
         // one long hold so the core backs up into the request side
         if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            stall_left     <= LONG_HOLD_CYCLES;
            rsp_ready      <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_xtea_block_cipher NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      int count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // key never written: all-zero key, field extremes in both modes
      @(negedge clock);
      push_block(KIND_ENCIPHER, 32'h0000_0000, 32'h0000_0000);
      push_block(KIND_DECIPHER, 32'h0000_0000, 32'h0000_0000);
      push_block(KIND_ENCIPHER, 32'hffff_ffff, 32'hffff_ffff);
      push_block(KIND_DECIPHER, 32'hffff_ffff, 32'hffff_ffff);
      push_block(KIND_ENCIPHER, 32'h0000_0000, 32'hffff_ffff);
      push_block(KIND_DECIPHER, 32'hffff_ffff, 32'h0000_0000);
      push_block(KIND_ENCIPHER, 32'h5555_5555, 32'haaaa_aaaa);
      push_block(KIND_DECIPHER, 32'haaaa_aaaa, 32'h5555_5555);
      push_round_trip(32'h0123_4567, 32'h89ab_cdef);
      wait_idle();

      // all-ones key
      load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      @(negedge clock);
      push_block(KIND_ENCIPHER, 32'h0000_0000, 32'h0000_0000);
      push_block(KIND_DECIPHER, 32'hffff_ffff, 32'hffff_ffff);
      push_round_trip(32'hdead_beef, 32'h0bad_f00d);
      wait_idle();

      // writes past the last key word must be dropped
      write_key_reg(CSR_IDX_UNUSED, 32'h0000_0000);
      write_key_reg(CSR_IDX_TOP, 32'h1234_5678);
      write_key_reg(CSR_IDX_W'($urandom_range(CSR_IDX_UNUSED, CSR_IDX_TOP)), $urandom);
      @(negedge clock);
      push_block(KIND_ENCIPHER, 32'h0000_0000, 32'h0000_0000);
      wait_idle();

      // random phases, each under a fresh key; phase 2 and the last one run without idling
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 1)
            load_key(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
         else
            load_key(rand_word(), rand_word(), rand_word(), rand_word());
         if ($urandom_range(0, 1) == 0)
            write_key_reg(CSR_IDX_W'($urandom_range(CSR_IDX_UNUSED, CSR_IDX_TOP)), $urandom);
         @(negedge clock);
         idle_on = (p != 2 && p != PHASE_COUNT - 1);
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 3) == 0) begin
               push_round_trip(rand_word(), rand_word());
               count += 2;
            end else begin
               push_block(($urandom_range(0, 1) == 0) ? KIND_ENCIPHER : KIND_DECIPHER,
                          rand_word(), rand_word());
               count++;
            end
         end
         wait_idle();
      end

      if (error_count == 0)
         $display("tb_xtea_block_cipher OK");
      else
         $display("tb_xtea_block_cipher NOT OK");
      $finish;
   end

endmodule

@@ xtea_block_cipher.f @@
rtl/core/xtea_pkg.sv
rtl/core/xtea_datapath.sv
rtl/core/xtea_ctrl.sv
rtl/core/xtea_block_cipher.sv
tb/sv/tb_xtea_block_cipher.sv
